// ===== rtl/ssparse_pkg.sv =====
// Shared types and character constants for the size string parser.
`default_nettype none

package ssparse_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_CASE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LO_G   = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LO_I   = 8'h69;
  localparam logic [CHAR_W-1:0] CH_LO_K   = 8'h6b;
  localparam logic [CHAR_W-1:0] CH_LO_M   = 8'h6d;

  localparam int unsigned SHIFT_K = 10;
  localparam int unsigned SHIFT_M = 20;
  localparam int unsigned SHIFT_G = 30;

  // Registered character waiting for the parser.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } ch_req_t;

  // Result request from the parser to the output register.
  typedef struct packed {
    logic               push;
    logic [VALUE_W-1:0] value;
    logic               status;
  } res_req_t;

endpackage

`default_nettype wire

// ===== rtl/ssparse_if.sv =====
// Valid/ready channel interfaces for characters and results.
`default_nettype none

interface ssparse_ch_if;
  import ssparse_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ssparse_res_if;
  import ssparse_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssparse_in_stage.sv =====
// Input register for incoming characters.
`default_nettype none

module ssparse_in_stage
  import ssparse_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ssparse_ch_if.sink  in_i,
  input  wire logic   consume_i,
  output ch_req_t     req_o
);

  logic              valid_q;
  logic [CHAR_W-1:0] ch_q;

  assign in_i.ready = !valid_q || consume_i;
  assign req_o      = '{valid: valid_q, ch: ch_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q <= in_i.ch;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ssparse_core.sv =====
// Parser state and per-character update.
`default_nettype none

module ssparse_core
  import ssparse_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ch_req_t  req_i,
  input  wire logic     slot_free_i,
  output logic          consume_o,
  output res_req_t      res_o
);

  typedef enum logic [2:0] {
    PH_DIGITS,
    PH_UNIT,
    PH_SFX_I,
    PH_SFX_B,
    PH_ERROR
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               is_nul;
  logic [CHAR_W-1:0]  lc;
  logic [3:0]         digit;

  assign is_nul = (req_i.ch == CH_NUL);
  // A zero byte waits until the output register can take its result.
  assign consume_o = req_i.valid && (!is_nul || slot_free_i);

  assign res_o.push   = consume_o && is_nul;
  assign res_o.status = (phase_q == PH_ERROR);
  assign res_o.value  = (phase_q == PH_ERROR) ? '0 : acc_q;

  // ASCII '0'..'9' carry the digit in the low nibble
  assign digit = req_i.ch[3:0];

  always_comb begin
    lc = req_i.ch;
    if (req_i.ch inside {[CH_UP_A:CH_UP_Z]}) begin
      lc = req_i.ch | CH_CASE;
    end
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    if (is_nul) begin
      phase_d = PH_DIGITS;
      acc_d   = '0;
    end else begin
      case (phase_q)
        PH_DIGITS: begin
          if (req_i.ch inside {[CH_ZERO:CH_NINE]}) begin
            // n*10 as n*8 + n*2, then the digit
            acc_d = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0}
                  + {{(VALUE_W-4){1'b0}}, digit};
          end else if (lc == CH_LO_G) begin
            acc_d   = acc_q << SHIFT_G;
            phase_d = PH_UNIT;
          end else if (lc == CH_LO_M) begin
            acc_d   = acc_q << SHIFT_M;
            phase_d = PH_UNIT;
          end else if (lc == CH_LO_K) begin
            acc_d   = acc_q << SHIFT_K;
            phase_d = PH_UNIT;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_UNIT: begin
          if (lc == CH_LO_I) begin
            phase_d = PH_SFX_I;
          end else if (lc == CH_LO_B) begin
            phase_d = PH_SFX_B;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_SFX_I: begin
          phase_d = (lc == CH_LO_B) ? PH_SFX_B : PH_ERROR;
        end
        default: begin
          phase_d = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DIGITS;
      acc_q   <= '0;
    end else if (consume_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

  // End of string always restarts the parse from a clean accumulator.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.push |=> (phase_q == PH_DIGITS) && (acc_q == '0))
    else $error("parser did not restart after end of string");

  // An error stays latched until the zero byte.
  a_err_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR) && !res_o.push |=> (phase_q == PH_ERROR))
    else $error("error phase left without end of string");

  // Nothing moves while no character is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !consume_o |=> $stable(acc_q) && $stable(phase_q))
    else $error("parser state changed without a character");

endmodule

`default_nettype wire

// ===== rtl/ssparse_out_stage.sv =====
// Result register toward the downstream sink.
`default_nettype none

module ssparse_out_stage
  import ssparse_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire res_req_t res_i,
  output logic          slot_free_o,
  ssparse_res_if.source out_o
);

  logic               valid_q;
  logic [VALUE_W-1:0] value_q;
  logic               status_q;

  assign slot_free_o  = !valid_q || out_o.ready;
  assign out_o.valid  = valid_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.push) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      value_q  <= res_i.value;
      status_q <= res_i.status;
    end
  end

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.push |-> (!valid_q || out_o.ready))
    else $error("result overwritten before it was taken");

  // A malformed string reports a zero count.
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q |-> (value_q == '0))
    else $error("error result carries a nonzero value");

endmodule

`default_nettype wire

// ===== rtl/size_suffix_string_parser.sv =====
// Top level of the size string parser: input register, parser, result register.
//
//  channel | dir | payload            | request moved
//  --------+-----+--------------------+---------------------------------------
//  in_i    | in  | ch[7:0]            | one character, zero byte ends a string
//  out_o   | out | value[63:0], status| one result per zero byte
//
// Rate: one character per cycle unless a zero byte waits on a full result
//   register; results are registered. The rate is set by the accumulator
//   update, one multiply-by-ten-and-add or constant shift per cycle.
// Reset: rst_ni clears both valid flags, the phase and the accumulator.
// Stalls: a stalled result holds its zero byte in the input register; other
//   characters keep flowing while the result register is full.
`default_nettype none

module size_suffix_string_parser
  import ssparse_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ssparse_ch_if.sink    in_i,
  ssparse_res_if.source out_o
);

  ch_req_t  ch_req;
  res_req_t res_req;
  logic     consume;
  logic     slot_free;

  // Character register; released when the parser takes the character.
  ssparse_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .consume_i (consume),
    .req_o     (ch_req)
  );

  // Phase and accumulator; emits a result request on the zero byte.
  ssparse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (ch_req),
    .slot_free_i (slot_free),
    .consume_o   (consume),
    .res_o       (res_req)
  );

  // Result register; frees its slot in the cycle the sink takes it.
  ssparse_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_req),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
